// ----- design/mqsb_pkg.sv -----
// Shared types and codes for the multi-queue shared slot buffer.
package mqsb_pkg;

    // Operation codes carried in the op field.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Status codes carried in the status field.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               op;
        logic [1:0]         queue_id;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic               store_full;
    } t_out_item;

    // Command class decided by the front end.
    typedef enum logic [1:0] {
        K_ENQ,
        K_DEQ,
        K_ENQ_BAD,
        K_DEQ_BAD
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [1:0]         queue_id;
        logic signed [31:0] value;
    } t_cmd;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_LINK,
        BS_COMMIT
    } t_bstate;

endpackage

// ----- design/mqsb_front.sv -----
// Front end: accepts items, classifies them and holds them in a two-entry queue.
module mqsb_front #(
    parameter int NUM_QUEUES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  mqsb_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output mqsb_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_take
);
    import mqsb_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_wr;
    logic       w_rd;
    logic       w_qok;
    t_cmd       w_cmd;

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_buf[r_rp];
    assign w_wr        = push && !full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    always_comb begin
        w_qok          = (int'(i_item.queue_id) < NUM_QUEUES);
        w_cmd.queue_id = i_item.queue_id;
        w_cmd.value    = i_item.value;
        unique case ({i_item.op, w_qok})
            {OP_ENQ, 1'b1}: w_cmd.kind = K_ENQ;
            {OP_DEQ, 1'b1}: w_cmd.kind = K_DEQ;
            {OP_ENQ, 1'b0}: w_cmd.kind = K_ENQ_BAD;
            default:        w_cmd.kind = K_DEQ_BAD;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        priority if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_buf[r_wp] <= w_cmd;
        end
    end

endmodule

// ----- design/mqsb_back.sv -----
// Back end: walks the slot lists and carries out one enqueue or dequeue at a time.
module mqsb_back #(
    parameter int NUM_QUEUES = 4,
    parameter int NUM_SLOTS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  mqsb_pkg::t_cmd     i_cmd,
    output logic               o_cmd_take,
    input  logic               i_res_ready,
    output logic               o_res_push,
    output mqsb_pkg::t_out_item o_res
);
    import mqsb_pkg::*;

    localparam int SW  = $clog2(NUM_SLOTS + 1);
    localparam int AW  = $clog2(NUM_SLOTS);
    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QIW = (QW > 2) ? QW : 2;
    localparam int DW  = DATA_WIDTH;
    localparam logic [SW-1:0] NULL_LINK = SW'(NUM_SLOTS);

    // Queue table word: head link above, tail slot below.
    logic [SW+AW-1:0] qmem [NUM_QUEUES];
    logic [SW-1:0]    link_mem [NUM_SLOTS];
    logic [DW-1:0]    data_mem [NUM_SLOTS];

    t_bstate          r_state;
    t_bstate          n_state;
    t_cmd             r_cmd;
    logic [QW-1:0]    r_qidx;
    logic [NUM_QUEUES-1:0] r_qvld;
    logic [NUM_QUEUES-1:0] n_qvld;
    logic [SW+AW-1:0] r_qrd;
    logic [SW-1:0]    r_head;
    logic [AW-1:0]    r_tail;
    logic [SW-1:0]    r_link_rd;
    logic [DW-1:0]    r_data_rd;
    logic [SW-1:0]    r_free_head;
    logic [SW-1:0]    n_free_head;
    logic [SW-1:0]    r_fill;
    logic [SW-1:0]    n_fill;

    logic [QIW-1:0]   w_qid_wide;
    logic [QW-1:0]    w_qidx_in;
    logic             w_good_in;
    logic [SW-1:0]    w_head;

    logic             q_re;
    logic             q_we;
    logic [SW+AW-1:0] q_wdata;
    logic             link_re;
    logic [AW-1:0]    link_raddr;
    logic             link_we;
    logic [AW-1:0]    link_waddr;
    logic [SW-1:0]    link_wdata;
    logic             data_re;
    logic [AW-1:0]    data_raddr;
    logic             data_we;
    logic [AW-1:0]    data_waddr;
    logic [DW-1:0]    data_wdata;

    assign w_qid_wide = QIW'(i_cmd.queue_id);
    assign w_qidx_in  = w_qid_wide[QW-1:0];
    assign w_good_in  = (i_cmd.kind == K_ENQ) || (i_cmd.kind == K_DEQ);
    // A queue never written since reset reads as empty.
    assign w_head     = r_qvld[r_qidx] ? r_qrd[SW+AW-1:AW] : NULL_LINK;

    always_comb begin
        n_state     = r_state;
        o_cmd_take  = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        q_re        = 1'b0;
        q_we        = 1'b0;
        q_wdata     = '0;
        link_re     = 1'b0;
        link_raddr  = '0;
        link_we     = 1'b0;
        link_waddr  = '0;
        link_wdata  = '0;
        data_re     = 1'b0;
        data_raddr  = '0;
        data_we     = 1'b0;
        data_waddr  = '0;
        data_wdata  = '0;
        n_free_head = r_free_head;
        n_fill      = r_fill;
        n_qvld      = r_qvld;
        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid && i_res_ready) begin
                    o_cmd_take = 1'b1;
                    q_re       = w_good_in;
                    n_state    = BS_LINK;
                end
            end
            BS_LINK: begin
                n_state = BS_COMMIT;
                if (r_cmd.kind == K_ENQ && r_free_head != NULL_LINK) begin
                    // Slots at or above the fill mark still hold their reset chain.
                    link_re    = (r_free_head < r_fill);
                    link_raddr = r_free_head[AW-1:0];
                end
                if (r_cmd.kind == K_DEQ && w_head != NULL_LINK) begin
                    link_re    = 1'b1;
                    link_raddr = w_head[AW-1:0];
                    data_re    = 1'b1;
                    data_raddr = w_head[AW-1:0];
                end
            end
            BS_COMMIT: begin
                n_state      = BS_IDLE;
                o_res_push   = 1'b1;
                o_res.status = ST_OK;
                unique case (r_cmd.kind)
                    K_ENQ: begin
                        if (r_free_head == NULL_LINK) begin
                            o_res.status = ST_FULL;
                        end else begin
                            n_free_head = (r_free_head < r_fill) ? r_link_rd
                                                                 : r_free_head + SW'(1);
                            if (r_free_head == r_fill) begin
                                n_fill = r_fill + SW'(1);
                            end
                            data_we    = 1'b1;
                            data_waddr = r_free_head[AW-1:0];
                            data_wdata = DW'($unsigned(r_cmd.value));
                            q_we       = 1'b1;
                            q_wdata    = {(r_head == NULL_LINK) ? r_free_head : r_head,
                                          r_free_head[AW-1:0]};
                            n_qvld[r_qidx] = 1'b1;
                            // The tail's link is left open until the next slot joins.
                            if (r_head != NULL_LINK) begin
                                link_we    = 1'b1;
                                link_waddr = r_tail;
                                link_wdata = r_free_head;
                            end
                        end
                    end
                    K_DEQ: begin
                        if (r_head == NULL_LINK) begin
                            o_res.status = ST_EMPTY;
                        end else begin
                            q_we       = 1'b1;
                            q_wdata    = {(r_head[AW-1:0] == r_tail) ? NULL_LINK : r_link_rd,
                                          r_tail};
                            link_we    = 1'b1;
                            link_waddr = r_head[AW-1:0];
                            link_wdata = r_free_head;
                            n_free_head = r_head;
                            o_res.data_out = 32'($signed(r_data_rd));
                        end
                    end
                    K_ENQ_BAD: o_res.status = ST_FULL;
                    default:   o_res.status = ST_EMPTY;
                endcase
                o_res.store_full = (n_free_head == NULL_LINK);
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_qvld      <= '0;
            r_free_head <= '0;
            r_fill      <= '0;
        end else begin
            r_state     <= n_state;
            r_qvld      <= n_qvld;
            r_free_head <= n_free_head;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd  <= i_cmd;
            r_qidx <= w_qidx_in;
        end
        if (r_state == BS_LINK) begin
            r_head <= w_head;
            r_tail <= r_qrd[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            qmem[r_qidx] <= q_wdata;
        end
        if (q_re) begin
            r_qrd <= qmem[w_qidx_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            r_link_rd <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (data_re) begin
            r_data_rd <= data_mem[data_raddr];
        end
    end

endmodule

// ----- design/mqsb_res_q.sv -----
// Result queue: two-entry buffer between the back end and the result port.
module mqsb_res_q (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mqsb_pkg::t_out_item i_res,
    output logic               o_ready,
    output logic               empty,
    output mqsb_pkg::t_out_item o_result,
    input  logic               pop
);
    import mqsb_pkg::*;

    t_out_item  r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_ready  = (r_cnt != 2'd2);
    assign empty    = (r_cnt == 2'd0);
    assign o_result = r_buf[r_rp];
    assign w_wr     = i_push && o_ready;
    assign w_rd     = pop && !empty;

    always_comb begin
        n_cnt = r_cnt;
        priority if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_buf[r_wp] <= i_res;
        end
    end

endmodule

// ----- design/multi_queue_shared_buffer.sv -----
// Top level: several FIFO queues sharing one linked slot store.
//
//   channel   direction  handshake            payload
//   items     in         push / full          i_item   (op, queue_id, value)
//   results   out        empty / pop          o_result (data_out, status, store_full)
//
// Each operation passes through the back end in order: queue table read, slot link and
// data read, then commit; each later step uses the registered memory read of the one before.
// Items wait in a two-entry front queue, results in a two-entry result queue, so
// either side may stall without holding up the other until its queue fills.
// Reset is synchronous and needs no clearing pass: a fill mark tracks which slots
// still hold their reset link chain.
module multi_queue_shared_buffer #(
    parameter int NUM_QUEUES = 4,
    parameter int NUM_SLOTS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mqsb_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output mqsb_pkg::t_out_item o_result
);
    import mqsb_pkg::*;

    logic      w_cmd_valid;
    t_cmd      w_cmd;
    logic      w_cmd_take;
    logic      w_res_ready;
    logic      w_res_push;
    t_out_item w_res;

    mqsb_front #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    mqsb_back #(
        .NUM_QUEUES (NUM_QUEUES),
        .NUM_SLOTS  (NUM_SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_res_ready (w_res_ready),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    mqsb_res_q u_res_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_push),
        .i_res    (w_res),
        .o_ready  (w_res_ready),
        .empty    (empty),
        .o_result (o_result),
        .pop      (pop)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the multi-queue shared slot buffer.
`timescale 1ns / 100ps

module tb_top;
    import mqsb_pkg::*;

    localparam int        NQUEUES     = 4;
    localparam int        NSLOTS      = 16;
    localparam logic [4:0] NULL_SLOT  = 5'd16;
    localparam int        STALL_LIMIT = 2000;
    localparam int        DRAIN_WAIT  = 20;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    multi_queue_shared_buffer uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predicted slot store, queue lists and free list
    logic signed [31:0] slot_word  [NSLOTS];
    logic [4:0]         slot_next  [NSLOTS];
    logic [4:0]         q_front    [NQUEUES];
    logic [3:0]         q_back     [NQUEUES];
    logic [4:0]         free_front;

    t_in_item  pending_ops[$];
    t_out_item expected_results[$];

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    logic [31:0] corner_words [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

    function automatic t_out_item apply_queue_op(t_in_item it);
        t_out_item  r;
        logic [4:0] s;
        logic [1:0] q;
        r.data_out = '0;
        r.status   = ST_OK;
        q = it.queue_id;
        if (it.op == OP_ENQ) begin
            if (free_front >= NULL_SLOT) begin
                r.status = ST_FULL;
            end else begin
                s = free_front;
                free_front = slot_next[s[3:0]];
                if (q_front[q] >= NULL_SLOT) begin
                    q_front[q] = s;
                end else begin
                    slot_next[q_back[q]] = s;
                end
                slot_next[s[3:0]] = NULL_SLOT;
                q_back[q] = s[3:0];
                slot_word[s[3:0]] = it.value;
            end
        end else begin
            if (q_front[q] >= NULL_SLOT) begin
                r.status = ST_EMPTY;
            end else begin
                s = q_front[q];
                q_front[q] = slot_next[s[3:0]];
                slot_next[s[3:0]] = free_front;
                free_front = s;
                r.data_out = slot_word[s[3:0]];
            end
        end
        r.store_full = (free_front >= NULL_SLOT);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_op(logic op, logic [1:0] q, logic [31:0] value);
        t_in_item it;
        it.op       = op;
        it.queue_id = q;
        it.value    = value;
        pending_ops.push_back(it);
    endtask

    // Mix enqueue-heavy, dequeue-heavy and balanced stretches so the store
    // fills up and drains repeatedly
    task automatic add_random_ops(int count);
        int       enq_pct;
        t_in_item it;
        enq_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 80;
                    1: enq_pct = 25;
                    default: enq_pct = 50;
                endcase
            end
            it.op       = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
            it.queue_id = 2'($urandom_range(NQUEUES - 1));
            it.value    = ($urandom_range(15) == 0) ? corner_words[2'($urandom_range(3))]
                                                    : $urandom;
            pending_ops.push_back(it);
        end
    endtask

    task automatic wait_sent();
        while (pending_ops.size() != 0) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Take an item transfer and predict its result
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            expected_results.push_back(apply_queue_op(i_item));
            void'(pending_ops.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            push   <= 1'b1;
            i_item <= pending_ops[0];
        end else begin
            push <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_result.data_out, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_result.data_out !== want.data_out)
                    report_mismatch("data_out", o_result.data_out, want.data_out);
                if (o_result.status !== want.status)
                    report_mismatch("status", 32'(o_result.status), 32'(want.status));
                if (o_result.store_full !== want.store_full)
                    report_mismatch("store_full", 32'(o_result.store_full),
                                    32'(want.store_full));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !(push && !full) && !(pop && !empty)) begin
            stall_cycles <= stall_cycles + 1;
        end else begin
            stall_cycles <= 0;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < NSLOTS; i++) begin
            slot_word[4'(i)] = '0;
            slot_next[4'(i)] = 5'(i + 1);
        end
        for (int i = 0; i < NQUEUES; i++) begin
            q_front[2'(i)] = NULL_SLOT;
            q_back[2'(i)]  = '0;
        end
        free_front = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty dequeue, fill the store, overflow, then partial drain
        add_op(OP_DEQ, 2'd0, 32'h1234_5678);
        for (int i = 0; i < NSLOTS; i++) begin
            add_op(OP_ENQ, 2'(i), (i < 4) ? corner_words[i[1:0]] : $urandom);
        end
        add_op(OP_ENQ, 2'd2, 32'hdead_beef);
        add_op(OP_DEQ, 2'd3, 32'h0);
        add_op(OP_ENQ, 2'd3, 32'h8000_0001);
        add_op(OP_DEQ, 2'd0, 32'hffff_ffff);
        add_op(OP_DEQ, 2'd0, 32'h0);
        add_op(OP_DEQ, 2'd1, 32'h0);
        add_op(OP_DEQ, 2'd2, 32'h0);

        // Hold off the sender until every result is back
        wait_idle();

        send_idle_pct = 30;
        recv_idle_pct = 52;
        add_random_ops(270);
        wait_sent();

        send_idle_pct = 52;
        recv_idle_pct = 30;
        add_random_ops(270);
        wait_sent();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_ops(260);
        wait_idle();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
